@@ hdl/usac_pkg.sv @@
// ----------------------------------------------------------------------------
// usac_pkg
// Shared types and constants of the sentence-aware text chunker.
// ----------------------------------------------------------------------------
package usac_pkg;

   localparam int POS_W = 11;   // window positions up to the chunk length + 3
   localparam int LEN_W = 10;

   localparam logic FUNC_BYTE  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic REG_CHUNK_SIZE = 1'b0;
   localparam logic REG_OVERLAP    = 1'b1;

   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_EXCL   = 8'h21;
   localparam logic [7:0] BYTE_QUEST  = 8'h3F;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] CJK_LEAD    = 8'hE3;
   localparam logic [7:0] CJK_MID     = 8'h80;
   localparam logic [7:0] CJK_PERIOD  = 8'h82;
   localparam logic [7:0] FW_LEAD     = 8'hEF;
   localparam logic [7:0] FW_MID      = 8'hBC;
   localparam logic [7:0] FW_EXCL     = 8'h81;
   localparam logic [7:0] FW_QUEST    = 8'h9F;

   // bit 0: lead byte, bit 1: a terminator ends here
   typedef struct packed {
      logic       func;
      logic [1:0] cls;
      logic       eot;
   } item_type;

endpackage

@@ hdl/usac_front.sv @@
// ----------------------------------------------------------------------------
// usac_front
// Classifies incoming bytes (lead byte, terminator end) and queues items.
// ----------------------------------------------------------------------------
module usac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [7:0]         req_byte_value,
   input  logic               req_end_of_text,
   output logic               q_valid,
   input  logic               q_pop,
   output usac_pkg::item_type q_item
);
   import usac_pkg::*;

   logic [7:0] p1_ff, p2_ff;
   logic       v1_ff, v2_ff, last_eot_ff;
   item_type   slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   logic       acc, both, term;
   logic [7:0] b, p1, p2;
   item_type   itm;

   assign req_ready = (cnt_ff != 2'd2);
   assign acc       = req_valid && req_ready;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = slot_ff[rp_ff];

   always_comb begin
      b    = req_byte_value;
      p1   = last_eot_ff ? 8'h00 : p1_ff;
      p2   = last_eot_ff ? 8'h00 : p2_ff;
      both = !last_eot_ff && v1_ff && v2_ff;
      term = (b == BYTE_LF) || (b == BYTE_EXCL) || (b == BYTE_QUEST)
          || (both && p2 == CJK_LEAD && p1 == CJK_MID && b == CJK_PERIOD)
          || (both && p2 == FW_LEAD && p1 == FW_MID && (b == FW_EXCL || b == FW_QUEST));
      itm.func = req_func;
      itm.cls  = {term, (b & CONT_MASK) != CONT_CODE};
      itm.eot  = req_end_of_text;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         last_eot_ff <= 1'b0;
         wp_ff       <= 1'b0;
         rp_ff       <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         if (acc) begin
            slot_ff[wp_ff] <= itm;
            wp_ff          <= !wp_ff;
            if (req_func == FUNC_BYTE) begin
               // a new text starts with an empty history
               p2_ff       <= p1;
               v2_ff       <= !last_eot_ff && v1_ff;
               p1_ff       <= b;
               v1_ff       <= 1'b1;
               last_eot_ff <= req_end_of_text;
            end
         end
         if (q_pop && q_valid) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, acc} - {1'b0, q_pop && q_valid};
      end
   end

endmodule

@@ hdl/usac_back.sv @@
// ----------------------------------------------------------------------------
// usac_back
// Keeps the class ring and plans chunks: lead search, backward terminator
// search, next-start search, then a readiness check for the following chunk.
// ----------------------------------------------------------------------------
module usac_back #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  usac_pkg::item_type        q_item,
   input  logic [usac_pkg::POS_W-1:0] chunk_eff,
   input  logic [8:0]                overlap,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_chunk_number,
   output logic [31:0]               rsp_start_offset,
   output logic [9:0]                rsp_chunk_length,
   output logic                      rsp_more_pending,
   output logic                      rsp_text_done
);
   import usac_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);

   typedef enum logic [2:0] {S_IDLE, S_LEAD, S_BACK, S_NEXT, S_UPD, S_EMIT} state_type;

   state_type        state_ff, state_in;
   logic [31:0]      br_ff, br_in, ws_ff, ws_in, id_ff, id_in, start_ff, start_in;
   logic             ended_ff, ended_in, more_ff, more_in, chk_ff, chk_in;
   logic             done_ff, done_in;
   logic [POS_W-1:0] k_ff, k_in, end_ff, end_in, cut_ff, cut_in, rd_off;
   logic             rv_ff, rv_in;
   logic [31:0]      rnum_ff, rnum_in, rstart_ff, rstart_in;
   logic [9:0]       rlen_ff, rlen_in;
   logic             rmore_ff, rmore_in, rdone_ff, rdone_in;

   logic [1:0]       ring [RING_DEPTH];
   logic [1:0]       rdata_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic [31:0]      rd_sum, lag;
   logic             k_past;
   logic [POS_W-1:0] n0;

   assign rd_sum  = ws_in + 32'(rd_off);
   assign rd_addr = rd_sum[IDX_W-1:0];
   assign lag     = br_ff - ws_ff;
   assign k_past  = 32'(k_ff) >= lag;

   always_comb begin
      state_in  = state_ff;
      br_in     = br_ff;
      ws_in     = ws_ff;
      id_in     = id_ff;
      start_in  = start_ff;
      ended_in  = ended_ff;
      more_in   = more_ff;
      chk_in    = chk_ff;
      done_in   = done_ff;
      k_in      = k_ff;
      end_in    = end_ff;
      cut_in    = cut_ff;
      rd_off    = '0;
      rv_in     = rv_ff && !rsp_ready;
      rnum_in   = rnum_ff;
      rstart_in = rstart_ff;
      rlen_in   = rlen_ff;
      rmore_in  = rmore_ff;
      rdone_in  = rdone_ff;
      q_pop     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = br_ff[IDX_W-1:0];
      n0        = (cut_ff > POS_W'(overlap)) ? cut_ff - POS_W'(overlap) : POS_W'(1);
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               chk_in = 1'b0;
               k_in   = chunk_eff;
               rd_off = chunk_eff;
               if (q_item.func == FUNC_BYTE) begin
                  // a byte after the text end starts a new text
                  wr_en    = 1'b1;
                  wr_addr  = ended_ff ? '0 : br_ff[IDX_W-1:0];
                  br_in    = ended_ff ? 32'd1 : br_ff + 32'd1;
                  ws_in    = ended_ff ? 32'd0 : ws_ff;
                  ended_in = q_item.eot;
               end
               state_in = S_LEAD;
            end
         end
         S_LEAD: begin
            if (lag == 32'd0 || (k_past && !ended_ff)) begin
               more_in  = 1'b0;
               state_in = chk_ff ? S_EMIT : S_IDLE;
            end else if (k_past || rdata_ff[0] || k_ff == chunk_eff + POS_W'(3)) begin
               if (chk_ff) begin
                  more_in  = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  end_in   = k_past ? lag[POS_W-1:0] : k_ff;
                  k_in     = end_in - POS_W'(1);
                  rd_off   = k_in;
                  state_in = S_BACK;
               end
            end else begin
               k_in   = k_ff + POS_W'(1);
               rd_off = k_in;
            end
         end
         S_BACK: begin
            if (rdata_ff[1]) begin
               cut_in   = k_ff + POS_W'(1);
               state_in = S_NEXT;
            end else if (k_ff == '0) begin
               cut_in   = end_ff;
               state_in = S_NEXT;
            end else begin
               k_in   = k_ff - POS_W'(1);
               rd_off = k_in;
            end
            if (state_in == S_NEXT) begin
               n0     = (cut_in > POS_W'(overlap)) ? cut_in - POS_W'(overlap) : POS_W'(1);
               k_in   = n0;
               rd_off = n0;
            end
         end
         S_NEXT: begin
            // advance to a lead byte, never past the cut
            if (k_ff < cut_ff && !rdata_ff[0]) begin
               k_in   = k_ff + POS_W'(1);
               rd_off = k_in;
            end else begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            start_in = ws_ff;
            done_in  = ended_ff && 32'(cut_ff) == lag;
            if (done_in) begin
               br_in    = '0;
               ws_in    = '0;
               ended_in = 1'b0;
               more_in  = 1'b0;
               state_in = S_EMIT;
            end else begin
               ws_in    = ws_ff + 32'(k_ff);
               chk_in   = 1'b1;
               k_in     = chunk_eff;
               rd_off   = chunk_eff;
               state_in = S_LEAD;
            end
         end
         S_EMIT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in     = 1'b1;
               rnum_in   = id_ff;
               rstart_in = start_ff;
               rlen_in   = cut_ff[LEN_W-1:0];
               rmore_in  = more_ff;
               rdone_in  = done_ff;
               id_in     = id_ff + 32'd1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         br_ff    <= '0;
         ws_ff    <= '0;
         id_ff    <= '0;
         ended_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         br_ff    <= br_in;
         ws_ff    <= ws_in;
         id_ff    <= id_in;
         ended_ff <= ended_in;
         rv_ff    <= rv_in;
      end
      start_ff  <= start_in;
      more_ff   <= more_in;
      chk_ff    <= chk_in;
      done_ff   <= done_in;
      k_ff      <= k_in;
      end_ff    <= end_in;
      cut_ff    <= cut_in;
      rnum_ff   <= rnum_in;
      rstart_ff <= rstart_in;
      rlen_ff   <= rlen_in;
      rmore_ff  <= rmore_in;
      rdone_ff  <= rdone_in;
   end

   // class ring, write-through on a same-address read
   always_ff @(posedge clock) begin
      if (wr_en) ring[wr_addr] <= q_item.cls;
      rdata_ff <= (wr_en && wr_addr == rd_addr) ? q_item.cls : ring[rd_addr];
   end

   assign rsp_valid        = rv_ff;
   assign rsp_chunk_number = rnum_ff;
   assign rsp_start_offset = rstart_ff;
   assign rsp_chunk_length = rlen_ff;
   assign rsp_more_pending = rmore_ff;
   assign rsp_text_done    = rdone_ff;

endmodule

@@ hdl/utf8_sentence_aware_chunker.sv @@
// ----------------------------------------------------------------------------
// utf8_sentence_aware_chunker
// Splits UTF-8 text into overlapping chunks cut after sentence terminators.
// ----------------------------------------------------------------------------
//  channel  ports   moves
//  req      req_*   one text byte or flush per transfer
//  rsp      rsp_*   one chunk descriptor per transfer
//  csr      csr_*   register write, index 0 chunk length, 1 overlap
//
//  An item that closes no chunk is popped and written to the class ring, then
//  the back end probes one window-end position after another.
//  A closing chunk adds one ring read per step of the backward terminator
//  search and of the next-start search.
//  A two-entry queue lets the front take bytes while the back end searches.
//  Synchronous reset; the class ring holds no reset value.
// ----------------------------------------------------------------------------
module utf8_sentence_aware_chunker #(
   parameter int RING_DEPTH = 1024,
   parameter int MAX_CHUNK  = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_byte_value,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_chunk_number,
   output logic [31:0] rsp_start_offset,
   output logic [9:0]  rsp_chunk_length,
   output logic        rsp_more_pending,
   output logic        rsp_text_done,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [9:0]  csr_wdata
);
   import usac_pkg::*;

   logic [9:0]       csize_ff;
   logic [8:0]       overlap_ff;
   logic [POS_W-1:0] chunk_eff;
   logic             q_valid, q_pop;
   item_type         q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         csize_ff   <= 10'd512;
         overlap_ff <= 9'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_CHUNK_SIZE: csize_ff   <= csr_wdata;
            REG_OVERLAP:    overlap_ff <= csr_wdata[8:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      if (csize_ff == '0)
         chunk_eff = POS_W'(1);
      else if (32'(csize_ff) > 32'(MAX_CHUNK))
         chunk_eff = POS_W'(MAX_CHUNK);
      else
         chunk_eff = POS_W'(csize_ff);
   end

   usac_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_byte_value  (req_byte_value),
      .req_end_of_text (req_end_of_text),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (q_item)
   );

   usac_back #(.RING_DEPTH(RING_DEPTH)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_pop            (q_pop),
      .q_item           (q_item),
      .chunk_eff        (chunk_eff),
      .overlap          (overlap_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_chunk_number (rsp_chunk_number),
      .rsp_start_offset (rsp_start_offset),
      .rsp_chunk_length (rsp_chunk_length),
      .rsp_more_pending (rsp_more_pending),
      .rsp_text_done    (rsp_text_done)
   );

endmodule

@@ tb/tb_utf8_sentence_aware_chunker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_sentence_aware_chunker
// Streams UTF-8 text with flushes into the chunker under random idling on
// both channels, across several size settings, and checks every chunk
// descriptor in order against an in-bench chunk planner or a typed row.
// ----------------------------------------------------------------------------
module tb_utf8_sentence_aware_chunker;
   import usac_pkg::*;

   localparam int          RING_N      = 1024;
   localparam int          CHUNK_CAP   = 512;
   localparam int          SETTLE      = 1200;
   localparam int          WD_LIMIT    = 20000;
   localparam int          BYTE_TARGET = 1200;

   typedef enum int {ROW_PREDICT, ROW_TYPED, ROW_NONE} row_kind_type;

   typedef struct {
      logic [31:0] number;
      logic [31:0] offset;
      logic [9:0]  length;
      logic        more;
      logic        done;
   } chunk_desc_type;

   typedef struct {
      logic           func;
      logic [7:0]     data;
      logic           eot;
      row_kind_type   kind;
      chunk_desc_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_BYTE;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_chunk_number;
   logic [31:0] rsp_start_offset;
   logic [9:0]  rsp_chunk_length;
   logic        rsp_more_pending;
   logic        rsp_text_done;
   logic        csr_we = 1'b0;
   logic        csr_index = REG_CHUNK_SIZE;
   logic [9:0]  csr_wdata = '0;

   utf8_sentence_aware_chunker DUT (.*);

   always #5 clock = ~clock;

   // chunk planner state
   logic [1:0]  class_ring [RING_N];
   int unsigned text_len, win_start, next_id, cfg_chunk, cfg_overlap;
   logic [7:0]  prev1, prev2;
   bit          prev1_ok, prev2_ok, text_ended;

   chunk_desc_type pending_chunks[$];
   int          fail_count = 0;
   int          bytes_sent = 0, flushes_sent = 0, chunks_seen = 0, phases_run = 0;
   bit          hold_rsp = 1'b0, quiet_mode = 1'b0;

   task automatic report(input string what, input logic [31:0] got, want);
      fail_count++;
      $display("MISMATCH %s: got %0d want %0d (chunk %0d)", what, got, want, chunks_seen);
   endtask

   function automatic void planner_reset();
      foreach (class_ring[i]) class_ring[i] = 2'b00;
      text_len = 0; win_start = 0; next_id = 0;
      cfg_chunk = 512; cfg_overlap = 64;
      prev1 = '0; prev2 = '0; prev1_ok = 0; prev2_ok = 0; text_ended = 0;
   endfunction

   function automatic void new_text();
      text_len = 0; win_start = 0; text_ended = 0;
      prev1_ok = 0; prev2_ok = 0; prev1 = '0; prev2 = '0;
   endfunction

   function automatic logic [1:0] class_of(input int unsigned rel);
      return class_ring[(win_start + rel) % RING_N];
   endfunction

   // window end, terminator cut and next start; 0 if the end is not known yet
   function automatic bit plan_window(output int unsigned cut, nxt, output bit last);
      int unsigned lag, c, wend, k;
      lag = text_len - win_start;
      c = cfg_chunk;
      wend = 0;
      cut = 0; nxt = 0; last = 0;
      if (c == 0) c = 1;
      if (c > CHUNK_CAP) c = CHUNK_CAP;
      if (lag == 0) return 0;
      for (k = c; k <= c + 3; k++) begin
         if (k >= lag) begin
            if (!text_ended) return 0;
            wend = lag;
            break;
         end
         if ((class_of(k) & 2'b01) != 2'b00 || k == c + 3) begin
            wend = k;
            break;
         end
      end
      cut = wend;
      for (k = wend; k > 0; k--) begin
         if ((class_of(k - 1) & 2'b10) != 2'b00) begin
            cut = k;
            break;
         end
      end
      nxt = (cut > cfg_overlap) ? cut - cfg_overlap : 1;
      while (nxt < cut && (class_of(nxt) & 2'b01) == 2'b00) nxt++;
      last = text_ended && cut == lag;
      return 1;
   endfunction

   function automatic bit chunk_ready();
      int unsigned a, b;
      bit d;
      return plan_window(a, b, d);
   endfunction

   function automatic bit predict_item(input logic func, input logic [7:0] data,
                                       input logic eot, output chunk_desc_type r);
      int unsigned cut, nxt;
      bit last, term;
      r = '{default: '0};
      if (func == FUNC_BYTE) begin
         if (text_ended) new_text();
         term = data == BYTE_LF || data == BYTE_EXCL || data == BYTE_QUEST
            || (prev1_ok && prev2_ok && prev2 == CJK_LEAD && prev1 == CJK_MID
                && data == CJK_PERIOD)
            || (prev1_ok && prev2_ok && prev2 == FW_LEAD && prev1 == FW_MID
                && (data == FW_EXCL || data == FW_QUEST));
         class_ring[text_len % RING_N] = {term, (data & CONT_MASK) != CONT_CODE};
         text_len++;
         prev2 = prev1; prev2_ok = prev1_ok;
         prev1 = data;  prev1_ok = 1;
         if (eot) text_ended = 1;
      end
      if (!plan_window(cut, nxt, last)) return 0;
      r.number = next_id;
      r.offset = win_start;
      r.length = cut[9:0];
      r.done   = last;
      next_id++;
      if (last) begin
         new_text();
         r.more = 0;
      end else begin
         win_start = win_start + nxt;
         r.more = chunk_ready();
      end
      return 1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // hold valid and payload until the transfer, then leave valid high for the next item
   task automatic drive_item(input logic func, input logic [7:0] data, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_byte_value  <= data;
      req_end_of_text <= eot;
      forever begin
         @(negedge clock);
         if (req_ready) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
      if (func == FUNC_BYTE) bytes_sent++;
      else flushes_sent++;
   endtask

   task automatic send(input logic func, input logic [7:0] data, input logic eot);
      chunk_desc_type r;
      if (predict_item(func, data, eot, r))
         pending_chunks.insert(pending_chunks.size(), r);
      drive_item(func, data, eot);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [9:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_CHUNK_SIZE) cfg_chunk = 32'(value);
      else cfg_overlap = 32'(value[8:0]);
   endtask

   task automatic flush_pending();
      while (chunk_ready() && $urandom_range(0, 9) != 0) send(FUNC_FLUSH, 8'h00, 1'b0);
   endtask

   // one random character or fragment of text
   task automatic send_token(input bit last);
      logic [7:0] seq[$];
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      seq = '{8'(($urandom_range(0, 25)) + 8'h61)};
      else if (pick < 48) seq = '{8'h20};
      else if (pick < 52) seq = '{BYTE_LF};
      else if (pick < 56) seq = '{BYTE_EXCL};
      else if (pick < 60) seq = '{BYTE_QUEST};
      else if (pick < 66) seq = '{8'hC3, 8'hA9};
      else if (pick < 72) seq = '{8'hE4, 8'hB8, 8'hAD};
      else if (pick < 76) seq = '{CJK_LEAD, CJK_MID, CJK_PERIOD};
      else if (pick < 79) seq = '{FW_LEAD, FW_MID, FW_EXCL};
      else if (pick < 82) seq = '{FW_LEAD, FW_MID, FW_QUEST};
      else if (pick < 86) seq = '{CJK_LEAD, CJK_MID};
      else if (pick < 89) seq = '{FW_LEAD, 8'h61, FW_QUEST};
      else if (pick < 93) begin
         repeat ($urandom_range(1, 7))
            seq.insert(seq.size(), 8'($urandom_range(8'h80, 8'hBF)));
      end else seq = '{8'($urandom_range(0, 255))};
      if (last) seq = seq[0:0];
      foreach (seq[i]) begin
         send(FUNC_BYTE, seq[i], last && i == seq.size() - 1);
         if ($urandom_range(0, 19) == 0) send(FUNC_FLUSH, 8'($urandom), 1'b0);
         flush_pending();
      end
   endtask

   task automatic send_text(input int len);
      for (int i = 0; i < len; i++) send_token(i == len - 1);
      // mostly drain the text; now and then drop what is left
      if ($urandom_range(0, 9) != 0)
         while (chunk_ready()) send(FUNC_FLUSH, 8'($urandom), 1'b1);
   endtask

   // receiver
   initial begin : receiver
      int stall;
      bit held;
      chunk_desc_type w;
      stall = 0;
      held  = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            held  = 1;
            stall = 600;
         end
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 99) < 25) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
         @(negedge clock);
         if (rsp_valid && rsp_ready) begin
            chunks_seen++;
            if (pending_chunks.size() == 0) begin
               report("unexpected chunk", rsp_chunk_number, 0);
            end else begin
               w = pending_chunks.pop_front();
               if (rsp_chunk_number !== w.number)
                  report("chunk_number", rsp_chunk_number, w.number);
               if (rsp_start_offset !== w.offset)
                  report("start_offset", rsp_start_offset, w.offset);
               if (rsp_chunk_length !== w.length)
                  report("chunk_length", 32'(rsp_chunk_length), 32'(w.length));
               if (rsp_more_pending !== w.more)
                  report("more_pending", 32'(rsp_more_pending), 32'(w.more));
               if (rsp_text_done !== w.done)
                  report("text_done", 32'(rsp_text_done), 32'(w.done));
            end
         end
      end
   end

   // watchdog: cycles without any transfer
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(negedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= WD_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d chunks outstanding",
                     idle, pending_chunks.size());
            $display("utf8_sentence_aware_chunker test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type   rows[$];
      chunk_desc_type r;
      int             p;
      planner_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes: a short text and an empty flush
      send(FUNC_FLUSH, 8'h00, 1'b0);
      for (int i = 0; i < 20; i++) send(FUNC_BYTE, 8'(8'h41 + i), i == 19);
      while (chunk_ready()) send(FUNC_FLUSH, 8'h00, 1'b0);
      wait_idle();
      write_reg(REG_CHUNK_SIZE, 10'd4);
      write_reg(REG_OVERLAP, 10'd1);

      rows = '{
         '{FUNC_FLUSH, 8'h00, 1'b0, ROW_NONE,   '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h61, 1'b0, ROW_NONE,   '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h62, 1'b0, ROW_NONE,   '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h21, 1'b1, ROW_TYPED,  '{1, 0, 3, 0, 1}},
         '{FUNC_FLUSH, 8'hFF, 1'b1, ROW_NONE,   '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h00, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hFF, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h80, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hBF, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h80, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h80, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h80, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hE3, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h80, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h82, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_FLUSH, 8'h00, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hEF, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hBC, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h81, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hEF, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'hBC, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h9F, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h0A, 1'b0, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h3F, 1'b1, ROW_PREDICT, '{0, 0, 0, 0, 0}},
         '{FUNC_BYTE,  8'h7A, 1'b1, ROW_PREDICT, '{0, 0, 0, 0, 0}}
      };
      foreach (rows[i]) begin
         if (predict_item(rows[i].func, rows[i].data, rows[i].eot, r)) begin
            if (rows[i].kind == ROW_TYPED)
               pending_chunks.insert(pending_chunks.size(), rows[i].want);
            else pending_chunks.insert(pending_chunks.size(), r);
         end else if (rows[i].kind == ROW_TYPED) begin
            pending_chunks.insert(pending_chunks.size(), rows[i].want);
         end
         drive_item(rows[i].func, rows[i].data, rows[i].eot);
         if (rows[i].kind == ROW_TYPED) next_id = rows[i].want.number + 1;
      end
      while (chunk_ready()) send(FUNC_FLUSH, 8'h00, 1'b0);

      // random phases across size settings, extremes included
      p = 0;
      while (bytes_sent < BYTE_TARGET) begin
         wait_idle();
         quiet_mode = (p % 5 == 3);
         case (p % 8)
            0: begin write_reg(REG_CHUNK_SIZE, 10'd1);    write_reg(REG_OVERLAP, 10'd0);   end
            1: begin write_reg(REG_CHUNK_SIZE, 10'd0);    write_reg(REG_OVERLAP, 10'd2);   end
            2: begin write_reg(REG_CHUNK_SIZE, 10'd512);  write_reg(REG_OVERLAP, 10'd511); end
            3: begin write_reg(REG_CHUNK_SIZE, 10'd1023); write_reg(REG_OVERLAP, 10'd100); end
            default: begin
               write_reg(REG_CHUNK_SIZE, 10'($urandom_range(2, 40)));
               write_reg(REG_OVERLAP, 10'($urandom_range(0, 45)));
            end
         endcase
         if (p == 1) hold_rsp = 1'b1;
         if (p % 8 == 2 || p % 8 == 3) begin
            if (p < 8) send_text($urandom_range(320, 340));
            else send_text($urandom_range(5, 40));
         end else begin
            repeat ($urandom_range(2, 5)) send_text($urandom_range(1, 60));
         end
         phases_run++;
         p++;
      end

      req_valid <= 1'b0;
      while (pending_chunks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d text bytes, %0d flushes, %0d chunks over %0d size settings",
               bytes_sent, flushes_sent, chunks_seen, phases_run + 2);
      $display("mismatches: %0d", fail_count);
      if (fail_count == 0) $display("utf8_sentence_aware_chunker test passed");
      else $display("utf8_sentence_aware_chunker test failed");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/usac_pkg.sv
hdl/usac_front.sv
hdl/usac_back.sv
hdl/utf8_sentence_aware_chunker.sv
tb/tb_utf8_sentence_aware_chunker.sv
